// File: hdl/assert_macros.svh
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock once reset is released
`define RCX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// value must stay stable while the condition stands
`define RCX_ASSERT_HOLD(lbl, clk, rst_n, ante, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> $stable(sig)) \
        else $error("hold check failed");

`endif

// File: hdl/rcx_pkg.sv
package rcx_pkg;

    localparam logic [31:0] RESET_PC     = 32'hFFFF_FFF0;
    localparam logic [19:0] PSW_RESET    = 20'h0_8000;
    localparam logic [19:0] PSW_WRITABLE = 20'hF_F3FF;
    localparam logic [31:0] WORD_ALIGN   = 32'hFFFF_FFFC;
    localparam logic [4:0]  SREG_PSW     = 5'd5;
    localparam logic [4:0]  SREG_CHCW    = 5'd24;

    localparam int FLAG_Z  = 0;
    localparam int FLAG_S  = 1;
    localparam int FLAG_OV = 2;
    localparam int FLAG_CY = 3;
    localparam int FLAG_ID = 12;

    localparam logic [2:0] BCOND_PREFIX = 3'b100;

    typedef enum logic [5:0] {
        OPC_MOV   = 6'h00,
        OPC_ADD   = 6'h01,
        OPC_SUB   = 6'h02,
        OPC_CMP   = 6'h03,
        OPC_JMP   = 6'h06,
        OPC_AND   = 6'h0D,
        OPC_MOVI  = 6'h10,
        OPC_ADDI5 = 6'h11,
        OPC_CMPI  = 6'h13,
        OPC_LDSR  = 6'h1C,
        OPC_SEI   = 6'h1E,
        OPC_MOVEA = 6'h28,
        OPC_ADDI  = 6'h29,
        OPC_JR    = 6'h2A,
        OPC_JAL   = 6'h2B,
        OPC_ANDI  = 6'h2D,
        OPC_MOVHI = 6'h2F,
        OPC_LDB   = 6'h30,
        OPC_LDH   = 6'h31,
        OPC_LDW   = 6'h33,
        OPC_STB   = 6'h34,
        OPC_STH   = 6'h35,
        OPC_STW   = 6'h37,
        OPC_INB   = 6'h38,
        OPC_INH   = 6'h39,
        OPC_INW   = 6'h3B,
        OPC_OUTB  = 6'h3C,
        OPC_OUTH  = 6'h3D,
        OPC_OUTW  = 6'h3F
    } opcode_t;

    typedef enum logic [2:0] {
        LK_LDB = 3'd0,
        LK_LDH = 3'd1,
        LK_LDW = 3'd2,
        LK_INB = 3'd3,
        LK_INH = 3'd4
    } load_kind_t;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2
    } bus_size_t;

    // architectural state held in flops
    typedef struct packed {
        logic [31:0] pc;
        logic [19:0] psw;
        logic        waiting;
        logic [4:0]  ldest;
        logic [2:0]  lkind;
    } arch_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        bus_valid;
        logic        bus_write;
        logic [1:0]  bus_size;
        logic [31:0] bus_addr;
        logic [31:0] bus_wdata;
        logic        load_pending;
        logic        fault;
    } result_t;

    typedef struct packed {
        result_t     res;
        arch_t       arch;
        logic        rf_we;
        logic [4:0]  rf_waddr;
        logic [31:0] rf_wdata;
    } exec_out_t;

endpackage

// File: hdl/rcx_regfile.sv
module rcx_regfile (
    input  logic        clk,
    input  logic        rd_en,
    input  logic [4:0]  raddr1,
    input  logic [4:0]  raddr2,
    output logic [31:0] rdata1,
    output logic [31:0] rdata2,
    input  logic        we,
    input  logic [4:0]  waddr,
    input  logic [31:0] wdata
);

    logic [31:0] mem [32];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered reads, old data on a same-edge write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata1 <= mem[raddr1];
            rdata2 <= mem[raddr2];
        end
    end

endmodule

// File: hdl/rcx_exec.sv
module rcx_exec (
    input  logic            op,
    input  logic [15:0]     instr,
    input  logic [15:0]     ext,
    input  logic [31:0]     load_data,
    input  logic [31:0]     reg1,
    input  logic [31:0]     reg2,
    input  rcx_pkg::arch_t  arch,
    output rcx_pkg::exec_out_t xo
);
    import rcx_pkg::*;

    logic [5:0]  opc;
    logic [4:0]  f1;
    logic [4:0]  f2;
    logic [31:0] sext16;
    logic [31:0] sext5;
    logic [31:0] addr;
    logic [31:0] pc4;
    logic [31:0] disp26;
    logic [31:0] alu_a;
    logic [31:0] alu_b;
    logic        alu_sub;
    logic [32:0] alu_sum;
    logic [31:0] alu_r;
    logic        alu_cy;
    logic        alu_ov;
    logic [31:0] and_r;
    logic        z;
    logic        s;
    logic        ov;
    logic        cy;
    logic        cond;
    logic        fault;
    logic        bus;
    logic        wr;
    logic [1:0]  size;
    logic [31:0] wdata;
    logic [31:0] npc;
    logic [31:0] ld_val;
    arch_t       na;
    logic        we;
    logic [4:0]  wa;
    logic [31:0] wd;

    assign opc    = instr[15:10];
    assign f2     = instr[9:5];
    assign f1     = instr[4:0];
    assign sext16 = {{16{ext[15]}}, ext};
    assign sext5  = {{27{f1[4]}}, f1};
    assign addr   = reg1 + sext16;
    assign pc4    = arch.pc + 32'd4;
    assign disp26 = {{6{instr[9]}}, instr[9:0], ext};
    assign z      = arch.psw[FLAG_Z];
    assign s      = arch.psw[FLAG_S];
    assign ov     = arch.psw[FLAG_OV];
    assign cy     = arch.psw[FLAG_CY];
    assign and_r  = reg2 & reg1;

    // shared adder for add, sub and compare
    always_comb
    begin
        alu_a   = reg2;
        alu_b   = reg1;
        alu_sub = 1'b0;
        unique case (opc)
            OPC_SUB, OPC_CMP: alu_sub = 1'b1;
            OPC_CMPI:
            begin
                alu_sub = 1'b1;
                alu_b   = sext5;
            end
            OPC_ADDI5: alu_b = sext5;
            OPC_ADDI:
            begin
                alu_a = reg1;
                alu_b = sext16;
            end
            default: alu_sub = 1'b0;
        endcase
    end

    always_comb
    begin
        alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + {32'd0, alu_sub};
        alu_r   = alu_sum[31:0];
        alu_cy  = alu_sub ? ~alu_sum[32] : alu_sum[32];
        alu_ov  = alu_sub ? ((alu_a[31] ^ alu_b[31]) & (alu_r[31] ^ alu_a[31]))
                          : (~(alu_a[31] ^ alu_b[31]) & (alu_r[31] ^ alu_a[31]));
    end

    always_comb
    begin
        unique case (instr[11:9])
            3'd0: cond = ov;
            3'd1: cond = cy;
            3'd2: cond = z;
            3'd3: cond = cy | z;
            3'd4: cond = s;
            3'd5: cond = 1'b1;
            3'd6: cond = ov ^ s;
            default: cond = (ov ^ s) | z;
        endcase
    end

    always_comb
    begin
        unique case (arch.lkind)
            LK_LDB:  ld_val = {{24{load_data[7]}}, load_data[7:0]};
            LK_LDH:  ld_val = {{16{load_data[15]}}, load_data[15:0]};
            LK_INB:  ld_val = {24'd0, load_data[7:0]};
            LK_INH:  ld_val = {16'd0, load_data[15:0]};
            default: ld_val = load_data;
        endcase
    end

    always_comb
    begin
        na    = arch;
        npc   = arch.pc + 32'd2;
        fault = 1'b0;
        bus   = 1'b0;
        wr    = 1'b0;
        size  = SZ_BYTE;
        wdata = 32'd0;
        we    = 1'b0;
        wa    = f2;
        wd    = alu_r;
        if (instr[15:13] == BCOND_PREFIX)
        begin
            if (cond != instr[12])
            begin
                npc = arch.pc + {{23{instr[8]}}, instr[8:0]};
            end
        end
        else
        begin
            unique case (opc)
                OPC_MOV:
                begin
                    we = 1'b1;
                    wd = reg1;
                end
                OPC_ADD, OPC_SUB, OPC_ADDI5, OPC_ADDI:
                begin
                    we = 1'b1;
                    na.psw[FLAG_Z]  = (alu_r == 32'd0);
                    na.psw[FLAG_S]  = alu_r[31];
                    na.psw[FLAG_CY] = alu_cy;
                    na.psw[FLAG_OV] = alu_ov;
                    if (opc == OPC_ADDI)
                    begin
                        npc = pc4;
                    end
                end
                OPC_CMP, OPC_CMPI:
                begin
                    na.psw[FLAG_Z]  = (alu_r == 32'd0);
                    na.psw[FLAG_S]  = alu_r[31];
                    na.psw[FLAG_CY] = alu_cy;
                    na.psw[FLAG_OV] = alu_ov;
                end
                OPC_JMP: npc = reg1;
                OPC_AND, OPC_ANDI:
                begin
                    we = 1'b1;
                    wd = (opc == OPC_AND) ? and_r : (reg1 & {16'd0, ext});
                    na.psw[FLAG_Z]  = (wd == 32'd0);
                    na.psw[FLAG_S]  = wd[31];
                    na.psw[FLAG_OV] = 1'b0;
                    if (opc == OPC_ANDI)
                    begin
                        npc = pc4;
                    end
                end
                OPC_MOVI:
                begin
                    we = 1'b1;
                    wd = sext5;
                end
                OPC_LDSR:
                begin
                    if (f1 == SREG_PSW)
                    begin
                        na.psw = reg2[19:0] & PSW_WRITABLE;
                    end
                    else if (f1 != SREG_CHCW)
                    begin
                        fault = 1'b1;
                    end
                end
                OPC_SEI: na.psw[FLAG_ID] = 1'b1;
                OPC_MOVEA:
                begin
                    npc = pc4;
                    we  = 1'b1;
                    wd  = addr;
                end
                OPC_JR: npc = arch.pc + disp26;
                OPC_JAL:
                begin
                    npc = arch.pc + disp26;
                    we  = 1'b1;
                    wa  = 5'd31;
                    wd  = pc4;
                end
                OPC_MOVHI:
                begin
                    npc = pc4;
                    we  = 1'b1;
                    wd  = reg1 + {ext, 16'd0};
                end
                OPC_LDB, OPC_LDH, OPC_LDW, OPC_INB, OPC_INH, OPC_INW:
                begin
                    npc        = pc4;
                    bus        = 1'b1;
                    na.waiting = 1'b1;
                    na.ldest   = f2;
                    unique case (opc)
                        OPC_LDB:
                        begin
                            na.lkind = LK_LDB;
                            size     = SZ_BYTE;
                        end
                        OPC_LDH:
                        begin
                            na.lkind = LK_LDH;
                            size     = SZ_HALF;
                        end
                        OPC_INB:
                        begin
                            na.lkind = LK_INB;
                            size     = SZ_BYTE;
                        end
                        OPC_INH:
                        begin
                            na.lkind = LK_INH;
                            size     = SZ_HALF;
                        end
                        default:
                        begin
                            na.lkind = LK_LDW;
                            size     = SZ_WORD;
                        end
                    endcase
                end
                OPC_STB, OPC_OUTB:
                begin
                    npc   = pc4;
                    bus   = 1'b1;
                    wr    = 1'b1;
                    size  = SZ_BYTE;
                    wdata = {24'd0, reg2[7:0]};
                end
                OPC_STH, OPC_OUTH:
                begin
                    npc   = pc4;
                    bus   = 1'b1;
                    wr    = 1'b1;
                    size  = SZ_HALF;
                    wdata = {16'd0, reg2[15:0]};
                end
                OPC_STW, OPC_OUTW:
                begin
                    npc   = pc4;
                    bus   = 1'b1;
                    wr    = 1'b1;
                    size  = SZ_WORD;
                    wdata = reg2;
                end
                default: fault = 1'b1;
            endcase
        end
        na.pc = npc;
    end

    always_comb
    begin
        xo          = '0;
        xo.arch     = arch;
        xo.rf_waddr = wa;
        xo.rf_wdata = wd;
        xo.res.next_pc = arch.pc;
        priority if (op)
        begin
            // load return, ignored when nothing is waiting
            xo.rf_waddr = arch.ldest;
            xo.rf_wdata = ld_val;
            xo.rf_we    = arch.waiting && (arch.ldest != 5'd0);
            xo.arch.waiting = 1'b0;
        end
        else if (arch.waiting)
        begin
            xo.res.load_pending = 1'b1;
        end
        else if (fault)
        begin
            xo.res.fault = 1'b1;
        end
        else
        begin
            xo.arch          = na;
            xo.rf_we         = we && (wa != 5'd0);
            xo.res.next_pc   = npc;
            xo.res.bus_valid = bus;
            xo.res.bus_write = wr;
            xo.res.bus_size  = bus ? size : SZ_BYTE;
            xo.res.bus_addr  = bus ? ((size == SZ_WORD) ? (addr & WORD_ALIGN) : addr) : 32'd0;
            xo.res.bus_wdata = wdata;
            xo.res.load_pending = na.waiting;
        end
    end

endmodule

// File: hdl/risc_cpu_execute_subset.sv
// integer execute unit for a subset of a 32-register risc instruction set.
// each input word is one instruction (tuser = 0) or the data for a waiting
// load (tuser = 1), and gives exactly one output word: the next pc, at most
// one bus request and the load-pending and fault flags. one word can be taken
// every cycle while the output is not stalled; an accepted word is registered
// in the operand-read stage, then its output word in the output register. the
// register file is a synchronous two-read, one-write memory: operands are read
// at accept and the write of the word ahead is forwarded around the memory.
// pc, status word and load bookkeeping sit in flops. a load returns its data
// as a separate input word; instructions arriving meanwhile are answered with
// load_pending set and the pc unchanged. r0 reads zero and ignores writes.
module risc_cpu_execute_subset (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // instr[15:0], ext[31:16], load_data[63:32]
    input  logic         s_tuser,   // op[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // next_pc[31:0], bus_valid[32], bus_write[33],
                                    // bus_size[35:34], bus_addr[67:36],
                                    // bus_wdata[99:68], load_pending[100],
                                    // fault[101], zero pad [103:102]
);
    import rcx_pkg::*;

    // operand-read stage
    logic        s1_valid_reg;
    logic        s1_op_reg;
    logic [15:0] s1_instr_reg;
    logic [15:0] s1_ext_reg;
    logic [31:0] s1_ldata_reg;

    // register write of the last executed word, for forwarding around the memory read
    logic        fwd_we_reg;
    logic [4:0]  fwd_addr_reg;
    logic [31:0] fwd_data_reg;

    arch_t       arch_reg;
    logic        out_valid_reg;
    result_t     out_reg;

    logic        accept;
    logic        exec_fire;
    logic [31:0] rdata1;
    logic [31:0] rdata2;
    logic [31:0] reg1;
    logic [31:0] reg2;
    logic [4:0]  f1;
    logic [4:0]  f2;
    exec_out_t   xo;

    assign exec_fire = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || exec_fire;
    assign accept    = s_tvalid && s_tready;

    assign f1 = s1_instr_reg[4:0];
    assign f2 = s1_instr_reg[9:5];

    rcx_regfile u_rf (
        .clk    (clk),
        .rd_en  (accept),
        .raddr1 (s_tdata[4:0]),
        .raddr2 (s_tdata[9:5]),
        .rdata1 (rdata1),
        .rdata2 (rdata2),
        .we     (exec_fire && xo.rf_we),
        .waddr  (xo.rf_waddr),
        .wdata  (xo.rf_wdata)
    );

    // r0 is hard zero, otherwise take the write that landed with the read
    always_comb
    begin
        priority if (f1 == 5'd0)
            reg1 = 32'd0;
        else if (fwd_we_reg && (fwd_addr_reg == f1))
            reg1 = fwd_data_reg;
        else
            reg1 = rdata1;
        priority if (f2 == 5'd0)
            reg2 = 32'd0;
        else if (fwd_we_reg && (fwd_addr_reg == f2))
            reg2 = fwd_data_reg;
        else
            reg2 = rdata2;
    end

    rcx_exec u_exec (
        .op        (s1_op_reg),
        .instr     (s1_instr_reg),
        .ext       (s1_ext_reg),
        .load_data (s1_ldata_reg),
        .reg1      (reg1),
        .reg2      (reg2),
        .arch      (arch_reg),
        .xo        (xo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            fwd_we_reg       <= 1'b0;
            arch_reg.pc      <= RESET_PC;
            arch_reg.psw     <= PSW_RESET;
            arch_reg.waiting <= 1'b0;
            arch_reg.ldest   <= 5'd0;
            arch_reg.lkind   <= LK_LDB;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (exec_fire)
                s1_valid_reg <= 1'b0;

            if (exec_fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (exec_fire)
            begin
                arch_reg   <= xo.arch;
                fwd_we_reg <= xo.rf_we;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= s_tuser;
            s1_instr_reg <= s_tdata[15:0];
            s1_ext_reg   <= s_tdata[31:16];
            s1_ldata_reg <= s_tdata[63:32];
        end
        if (exec_fire)
        begin
            out_reg      <= xo.res;
            fwd_addr_reg <= xo.rf_waddr;
            fwd_data_reg <= xo.rf_wdata;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.fault, out_reg.load_pending, out_reg.bus_wdata,
                       out_reg.bus_addr, out_reg.bus_size, out_reg.bus_write,
                       out_reg.bus_valid, out_reg.next_pc};

endmodule

// File: hdl/rcx_checker.sv
`include "assert_macros.svh"

module rcx_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);

    // a stalled output word holds
    `RCX_ASSERT_HOLD(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tdata)
    // a faulting word carries no access
    `RCX_ASSERT_IMPL(a_fault_no_bus, clk, rst_n, m_tvalid && m_tdata[101], !m_tdata[32])
    // word accesses are aligned
    `RCX_ASSERT_IMPL(a_word_align, clk, rst_n, m_tvalid && m_tdata[32] && (m_tdata[35:34] == 2'd2), m_tdata[37:36] == 2'd0)
    // an idle bus field set is all zero
    `RCX_ASSERT_IMPL(a_idle_bus_zero, clk, rst_n, m_tvalid && !m_tdata[32], (m_tdata[99:33] == 67'd0) && (m_tdata[103:102] == 2'd0))
    // the input only stalls behind a stalled output word
    `RCX_ASSERT_IMPL(a_stall_cause, clk, rst_n, s_tvalid && !s_tready, m_tvalid && !m_tready)

endmodule

bind risc_cpu_execute_subset rcx_checker u_rcx_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
